// ===== sv/tcw_pkg.sv =====
package tcw_pkg;

  // input item kinds (carried in s_tuser)
  localparam logic [1:0] MODE_PUT   = 2'd0;
  localparam logic [1:0] MODE_CLEAR = 2'd1;
  localparam logic [1:0] MODE_READ  = 2'd2;

  // configuration register indexes
  localparam logic [1:0] CFG_TEXT_ATTR  = 2'd0;
  localparam logic [1:0] CFG_CLEAR_ATTR = 2'd1;
  localparam logic [1:0] CFG_CLEAR_CHAR = 2'd2;

  localparam logic [7:0] TEXT_ATTR_RST  = 8'h07;
  localparam logic [7:0] CLEAR_ATTR_RST = 8'h0f;
  localparam logic [7:0] CLEAR_CHAR_RST = 8'h20;
  localparam logic [7:0] NEWLINE_CODE   = 8'h0a;

  typedef enum logic [2:0] {
    ST_INIT,
    ST_IDLE,
    ST_DECODE,
    ST_EXEC,
    ST_SWEEP,
    ST_DONE
  } state_t;

  // controller -> datapath
  typedef struct packed {
    logic load_item;
    logic sweep_fill;
    logic sweep_step;
    logic put_exec;
    logic read_issue;
    logic result_load;
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic [1:0] mode;
    logic       sweep_last;
    logic       needs_scroll;
    logic       out_free;
  } status_t;

endpackage

// ===== sv/tcw_ctrl.sv =====
module tcw_ctrl import tcw_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    s_tvalid,
  output logic    s_tready,
  input  status_t status,
  output cmd_t    cmd
);

  state_t state, state_next;

  // state register; reset starts the screen clearing pass
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_INIT;
    end else begin
      state <= state_next;
    end
  end

  // next state and commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    s_tready   = 1'b0;
    case (state)
      ST_INIT: begin
        cmd.sweep_step = 1'b1;
        if (status.sweep_last) state_next = ST_IDLE;
      end
      ST_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          cmd.load_item = 1'b1;
          state_next    = ST_DECODE;
        end
      end
      ST_DECODE: begin
        case (status.mode)
          MODE_PUT: state_next = ST_EXEC;
          MODE_CLEAR: begin
            cmd.sweep_fill = 1'b1;
            state_next     = ST_SWEEP;
          end
          MODE_READ: begin
            cmd.read_issue = 1'b1;
            state_next     = ST_DONE;
          end
          default: state_next = ST_DONE;
        endcase
      end
      ST_EXEC: begin
        cmd.put_exec = 1'b1;
        state_next   = status.needs_scroll ? ST_SWEEP : ST_DONE;
      end
      ST_SWEEP: begin
        cmd.sweep_step = 1'b1;
        if (status.sweep_last) state_next = ST_DONE;
      end
      ST_DONE: begin
        if (status.out_free) begin
          cmd.result_load = 1'b1;
          state_next      = ST_IDLE;
        end
      end
      default: state_next = ST_INIT;
    endcase
  end

endmodule

// ===== sv/tcw_datapath.sv =====
module tcw_datapath import tcw_pkg::*; #(
  parameter int COLUMNS = 80,
  parameter int ROWS    = 25
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [7:0]  cfg_data,
  input  logic [1:0]  s_tuser,
  input  logic [23:0] s_tdata,
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,
  input  cmd_t        cmd,
  output status_t     status
);

  localparam int CELLS  = ROWS * COLUMNS;
  localparam int ADDR_W = $clog2(CELLS);
  localparam int CNT_W  = $clog2(CELLS + 1);
  localparam int COL_W  = $clog2(COLUMNS);
  localparam int ROW_W  = $clog2(ROWS);

  localparam logic [ADDR_W-1:0] LAST_ADDR  = ADDR_W'(CELLS - 1);
  localparam logic [ADDR_W-1:0] COLS_A     = ADDR_W'(COLUMNS);
  localparam logic [ADDR_W-1:0] BOTTOM_LIN = ADDR_W'((ROWS - 1) * COLUMNS);
  localparam logic [ADDR_W:0]   CELLS_X    = (ADDR_W + 1)'(CELLS);
  localparam logic [COL_W-1:0]  LAST_COL   = COL_W'(COLUMNS - 1);
  localparam logic [ROW_W-1:0]  LAST_ROW   = ROW_W'(ROWS - 1);
  localparam logic [CNT_W-1:0]  CELLS_CNT  = CNT_W'(CELLS);
  localparam logic [CNT_W-1:0]  COLS_CNT   = CNT_W'(COLUMNS);

  // screen store; rows form a ring starting at base
  logic [15:0] mem [CELLS];

  logic [7:0] text_attr, clear_attr, clear_char;

  logic [1:0]  item_mode;
  logic [7:0]  item_char;
  logic [10:0] item_idx;

  logic [ROW_W-1:0]  cursor_row;
  logic [COL_W-1:0]  cursor_col;
  logic [ADDR_W-1:0] cursor_lin;
  logic [ADDR_W-1:0] base;

  logic [ADDR_W-1:0] sweep_addr;
  logic [CNT_W-1:0]  sweep_left;
  logic [15:0]       sweep_value;

  logic [15:0] rd_data;
  logic        rd_in_range;
  logic        scroll_flag;

  logic              is_newline, wrap, needs_scroll;
  logic [ADDR_W-1:0] cur_phys, rd_phys, base_plus;
  logic [31:0]       idx_w, lin_w;
  logic              idx_ok;
  logic              mem_we;
  logic [ADDR_W-1:0] mem_waddr;
  logic [15:0]       mem_wdata;
  logic [15:0]       res_cell;

  // ring offset add with a single wrap correction
  function automatic logic [ADDR_W-1:0] ring_add(input logic [ADDR_W-1:0] a,
                                                  input logic [ADDR_W-1:0] b);
    logic [ADDR_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    if (s >= CELLS_X) s = s - CELLS_X;
    return s[ADDR_W-1:0];
  endfunction

  // put-character decode
  always_comb begin
    is_newline   = (item_char == NEWLINE_CODE);
    wrap         = is_newline || (cursor_col == LAST_COL);
    needs_scroll = wrap && (cursor_row == LAST_ROW);
    cur_phys     = ring_add(cursor_lin, base);
    base_plus    = ring_add(base, COLS_A);
    idx_w        = 32'(item_idx);
    idx_ok       = idx_w < 32'(CELLS);
    rd_phys      = ring_add(ADDR_W'(idx_w), base);
  end

  // single write port: sweep or printed character
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = sweep_addr;
    mem_wdata = sweep_value;
    if (cmd.sweep_step) begin
      mem_we = 1'b1;
    end else if (cmd.put_exec && !is_newline) begin
      mem_we    = 1'b1;
      mem_waddr = cur_phys;
      mem_wdata = {text_attr, item_char};
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_waddr] <= mem_wdata;
    if (cmd.read_issue) rd_data <= mem[rd_phys];
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      text_attr  <= TEXT_ATTR_RST;
      clear_attr <= CLEAR_ATTR_RST;
      clear_char <= CLEAR_CHAR_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_TEXT_ATTR:  text_attr  <= cfg_data;
        CFG_CLEAR_ATTR: clear_attr <= cfg_data;
        CFG_CLEAR_CHAR: clear_char <= cfg_data;
        default: ;
      endcase
    end
  end

  // captured item and per-item flags
  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      item_mode <= s_tuser;
      item_char <= s_tdata[7:0];
      item_idx  <= s_tdata[18:8];
    end
    if (cmd.read_issue) rd_in_range <= idx_ok;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      scroll_flag <= 1'b0;
    end else if (cmd.load_item) begin
      scroll_flag <= 1'b0;
    end else if (cmd.put_exec) begin
      scroll_flag <= needs_scroll;
    end
  end

  // cursor, ring base and sweep control
  always_ff @(posedge clk) begin
    if (rst) begin
      cursor_row  <= '0;
      cursor_col  <= '0;
      cursor_lin  <= '0;
      base        <= '0;
      sweep_addr  <= '0;
      sweep_left  <= CELLS_CNT;
      sweep_value <= '0;
    end else begin
      if (cmd.sweep_step) begin
        sweep_addr <= (sweep_addr == LAST_ADDR) ? '0 : sweep_addr + 1'b1;
        sweep_left <= sweep_left - 1'b1;
      end
      if (cmd.sweep_fill) begin
        sweep_addr  <= '0;
        sweep_left  <= CELLS_CNT;
        sweep_value <= {clear_attr, clear_char};
        cursor_row  <= '0;
        cursor_col  <= '0;
        cursor_lin  <= '0;
        base        <= '0;
      end
      if (cmd.put_exec) begin
        if (!wrap) begin
          cursor_col <= cursor_col + 1'b1;
          cursor_lin <= cursor_lin + 1'b1;
        end else if (needs_scroll) begin
          // old top row becomes the blank bottom row
          cursor_col  <= '0;
          cursor_lin  <= BOTTOM_LIN;
          base        <= base_plus;
          sweep_addr  <= base;
          sweep_left  <= COLS_CNT;
          sweep_value <= '0;
        end else begin
          cursor_col <= '0;
          cursor_row <= cursor_row + 1'b1;
          cursor_lin <= cursor_lin - ADDR_W'(cursor_col) + COLS_A;
        end
      end
    end
  end

  // output register
  always_comb begin
    lin_w    = 32'(cursor_lin);
    res_cell = (item_mode == MODE_READ && rd_in_range) ? rd_data : 16'h0000;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.result_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.result_load) begin
      m_tdata <= {4'b0000, scroll_flag, res_cell[15:8], res_cell[7:0], lin_w[10:0]};
    end
  end

  always_comb begin
    status.mode         = item_mode;
    status.sweep_last   = (sweep_left == CNT_W'(1));
    status.needs_scroll = needs_scroll;
    status.out_free     = !m_tvalid || m_tready;
  end

endmodule

// ===== sv/text_console_writer.sv =====
// Text console writer. Keeps a ROWS x COLUMNS screen of 16-bit cells
// (attribute in the high byte, character in the low byte) and a cursor.
// Items arrive on s_*: s_tuser selects put character, clear screen or read
// cell; every item returns one result on m_*, holding the linear cursor
// position after the item. A plain character or newline passes through
// the decode, execute and done states; a line feed past the last row
// adds a sweep to blank the new bottom row (rows are kept as a ring
// in the cell memory, so a scroll only moves the ring base). A clear
// sweeps all ROWS*COLUMNS cells, one cell per cycle through the single
// memory write port, and a read or an unused mode code goes from decode
// to done. The next item is taken only once the result is loaded, and a
// result is loaded only when the output register is free. After reset a
// clearing pass zeroes every cell before the first item is taken;
// configuration writes on cfg_* are taken at any time.
module text_console_writer import tcw_pkg::*; #(
  parameter int COLUMNS = 80,
  parameter int ROWS    = 25
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [7:0]  cfg_data,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [23:0] s_tdata,   // [7:0] char_code, [18:8] cell_index, rest zero
  input  logic [1:0]  s_tuser,   // [1:0] mode
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata    // [10:0] cursor_pos, [18:11] read_char,
                                 // [26:19] read_attr, [27] scrolled, rest zero
);

  cmd_t    cmd;
  status_t status;

  tcw_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .status   (status),
    .cmd      (cmd)
  );

  tcw_datapath #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .s_tuser   (s_tuser),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cmd       (cmd),
    .status    (status)
  );

endmodule

// ===== sv/tcw_checker.sv =====
module tcw_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [31:0] m_tdata
);

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("result changed while stalled");

  // no item is taken in the cycle after reset (clearing pass runs)
  a_init_busy: assert property (@(posedge clk)
    rst |=> !s_tready)
    else $error("input ready during clearing pass");

  // one item at a time
  a_one_item: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("input ready right after a transaction");

  // a scroll comes only from a put item, whose read fields are zero
  a_scroll_no_read: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[27] |-> m_tdata[26:11] == 16'h0000)
    else $error("scrolled result carries read data");

endmodule

bind text_console_writer tcw_checker u_tcw_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);

// ===== tb/tb.sv =====
module tb;
  import tcw_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int COLUMNS = 80;
  localparam int ROWS    = 25;
  localparam int CELLS   = COLUMNS * ROWS;

  // mode code the block leaves unused
  localparam logic [1:0] MODE_UNUSED = 2'd3;

  // clear walks every cell, so idle means at least that long
  localparam int SETTLE_CYCLES = CELLS + 16;
  localparam int LONG_HOLD     = 400;
  localparam int LIMIT_CYCLES  = 3_000_000;
  localparam int MAX_PRINTED   = 40;

  // one result, laid out as m_tdata[27:0]
  typedef struct packed {
    logic        scrolled;
    logic [7:0]  attr;
    logic [7:0]  chr;
    logic [10:0] pos;
  } console_result_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_index = CFG_TEXT_ATTR;
  logic [7:0]  cfg_data = 8'h00;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [23:0] s_tdata = 24'h0;
  logic [1:0]  s_tuser = MODE_PUT;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [31:0] m_tdata;

  text_console_writer #(
    .COLUMNS(COLUMNS),
    .ROWS   (ROWS)
  ) dut (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),   // [7:0] char_code, [18:8] cell_index, rest zero
    .s_tuser  (s_tuser),   // [1:0] mode
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)    // [10:0] cursor_pos, [18:11] read_char,
                           // [26:19] read_attr, [27] scrolled, rest zero
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // shadow copy of the console state
  logic [15:0]     shadow_screen [CELLS];
  int unsigned     cur_row;
  int unsigned     cur_col;
  logic [7:0]      text_attr_q;
  logic [7:0]      clear_attr_q;
  logic [7:0]      clear_char_q;
  console_result_t pending_results [$];

  int error_count = 0;
  int burst_left  = 0;
  int cycle_count = 0;

  // long receiver hold-off handshake between test and receiver
  bit hold_req = 1'b0;
  bit hold_ack = 1'b0;
  int hold_left = 0;
  logic [9:0] rx_tick = '0;

  initial begin
    for (int i = 0; i < CELLS; i++) shadow_screen[i] = 16'h0;
    cur_row      = 0;
    cur_col      = 0;
    text_attr_q  = TEXT_ATTR_RST;
    clear_attr_q = CLEAR_ATTR_RST;
    clear_char_q = CLEAR_CHAR_RST;
  end

  // move the cursor down one row; scroll up past the bottom
  function automatic bit line_feed();
    cur_row++;
    if (cur_row >= ROWS) begin
      cur_row = ROWS - 1;
      for (int i = 0; i < CELLS - COLUMNS; i++) shadow_screen[i] = shadow_screen[i + COLUMNS];
      for (int i = CELLS - COLUMNS; i < CELLS; i++) shadow_screen[i] = 16'h0;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  // update the shadow console with one item and return its result
  function automatic console_result_t apply_console_item(logic [1:0] mode, logic [7:0] ch,
                                                         logic [10:0] idx);
    console_result_t r;
    int unsigned lin;
    r = '0;
    case (mode)
      MODE_PUT: begin
        if (ch == NEWLINE_CODE) begin
          cur_col = 0;
          r.scrolled = line_feed();
        end else begin
          lin = cur_row * COLUMNS + cur_col;
          if (lin < CELLS) shadow_screen[lin] = {text_attr_q, ch};
          cur_col++;
          if (cur_col >= COLUMNS) begin
            cur_col = 0;
            r.scrolled = line_feed();
          end
        end
      end
      MODE_CLEAR: begin
        for (int i = 0; i < CELLS; i++) shadow_screen[i] = {clear_attr_q, clear_char_q};
        cur_row = 0;
        cur_col = 0;
      end
      MODE_READ: begin
        if (idx < CELLS) begin
          r.chr  = shadow_screen[idx][7:0];
          r.attr = shadow_screen[idx][15:8];
        end
      end
      default: ;
    endcase
    lin = cur_row * COLUMNS + cur_col;
    r.pos = lin[10:0];
    return r;
  endfunction

  task automatic report_error(string what, int unsigned got_v, int unsigned want_v);
    if (error_count < MAX_PRINTED)
      $display("%0t ns: %s mismatch: got %0d, expected %0d", $time, what, got_v, want_v);
    error_count++;
  endtask

  // send one item; bursts of random length separated by idle gaps
  task automatic send_item(logic [1:0] mode, logic [7:0] ch, logic [10:0] idx);
    if (burst_left == 0) begin
      repeat ($urandom_range(1, 8)) @(posedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 8);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= mode;
    s_tdata  <= {5'b0, idx, ch};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    pending_results.push_back(apply_console_item(mode, ch, idx));
    burst_left--;
    if (burst_left == 0) s_tvalid <= 1'b0;
  endtask

  task automatic sender_rest();
    if (burst_left != 0) begin
      s_tvalid <= 1'b0;
      burst_left = 0;
    end
  endtask

  // wait until every transaction has come back
  task automatic drain(int extra);
    sender_rest();
    while (pending_results.size() != 0) @(posedge clk);
    repeat (extra) @(posedge clk);
  endtask

  task automatic write_config(logic [1:0] idx, logic [7:0] val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      CFG_TEXT_ATTR:  text_attr_q  = val;
      CFG_CLEAR_ATTR: clear_attr_q = val;
      CFG_CLEAR_CHAR: clear_char_q = val;
      default: ;
    endcase
  endtask

  task automatic set_attrs(logic [7:0] text_a, logic [7:0] clear_a, logic [7:0] clear_c);
    drain(SETTLE_CYCLES);
    write_config(CFG_TEXT_ATTR, text_a);
    write_config(CFG_CLEAR_ATTR, clear_a);
    write_config(CFG_CLEAR_CHAR, clear_c);
  endtask

  function automatic logic [7:0] pick_char();
    if ($urandom_range(0, 99) < 85) return 8'($urandom_range(32, 126));
    return 8'($urandom_range(0, 255));
  endfunction

  // reads mostly land just behind the cursor, where text was printed
  task automatic send_random_read();
    int unsigned roll;
    int unsigned lin;
    logic [10:0] idx;
    roll = $urandom_range(0, 99);
    lin  = cur_row * COLUMNS + cur_col;
    if (roll < 60) idx = 11'((lin + CELLS - $urandom_range(1, 200)) % CELLS);
    else if (roll < 90) idx = 11'($urandom_range(0, CELLS - 1));
    else idx = 11'($urandom_range(CELLS, 2047));
    send_item(MODE_READ, 8'($urandom), idx);
  endtask

  // screen after reset: zero cells, out-of-range reads, unused mode
  task automatic test_reset_screen();
    send_item(MODE_READ, 8'hff, 11'd0);
    send_item(MODE_READ, 8'h00, 11'(CELLS - 1));
    send_item(MODE_READ, 8'h55, 11'(CELLS));
    send_item(MODE_READ, 8'haa, 11'h7ff);
    send_item(MODE_UNUSED, 8'hff, 11'h7ff);
  endtask

  // null byte, top byte, a letter, newline, then read the three cells back
  task automatic test_put_basic();
    send_item(MODE_PUT, 8'h00, 11'h7ff);
    send_item(MODE_PUT, 8'hff, 11'h000);
    send_item(MODE_PUT, 8'h41, 11'h3ff);
    send_item(MODE_PUT, NEWLINE_CODE, 11'h400);
    send_item(MODE_READ, 8'h00, 11'd0);
    send_item(MODE_READ, 8'h00, 11'd1);
    send_item(MODE_READ, 8'h00, 11'd2);
  endtask

  task automatic test_clear_defaults();
    send_item(MODE_CLEAR, 8'h0a, 11'd5);
    send_item(MODE_READ, 8'h00, 11'd0);
    send_item(MODE_READ, 8'h00, 11'(CELLS - 1));
  endtask

  // receiver holds off for a long stretch while puts keep coming
  task automatic test_result_backpressure(int count);
    @(posedge clk);
    hold_req <= ~hold_req;
    for (int k = 0; k < count; k++) begin
      if (k % 9 == 8) send_item(MODE_PUT, NEWLINE_CODE, 11'($urandom));
      else send_item(MODE_PUT, pick_char(), 11'($urandom));
    end
  endtask

  // lines of random text with reads mixed in; most lines are short so the
  // cursor reaches the bottom and scrolls
  task automatic run_text_phase(int count, bit start_clear);
    int sent;
    int line_len;
    int unsigned roll;
    sent = 0;
    if (start_clear) begin
      send_item(MODE_CLEAR, 8'($urandom), 11'($urandom));
      send_item(MODE_READ, 8'($urandom), 11'($urandom_range(0, CELLS - 1)));
      sent = 2;
    end
    while (sent < count) begin
      roll = $urandom_range(0, 99);
      if (roll < 92) line_len = $urandom_range(0, 3);
      else if (roll < 97) line_len = $urandom_range(4, 79);
      else line_len = $urandom_range(80, 170);
      for (int k = 0; k < line_len && sent < count; k++) begin
        roll = $urandom_range(0, 99);
        if (roll < 12) send_random_read();
        else if (roll < 14) send_item(MODE_UNUSED, 8'($urandom), 11'($urandom));
        else send_item(MODE_PUT, pick_char(), 11'($urandom));
        sent++;
      end
      send_item(MODE_PUT, NEWLINE_CODE, 11'($urandom));
      sent++;
      if ($urandom_range(0, 9) < 3) begin
        send_item(MODE_PUT, NEWLINE_CODE, 11'($urandom));
        sent++;
      end
      if ($urandom_range(0, 59) == 0) begin
        send_item(MODE_CLEAR, 8'($urandom), 11'($urandom));
        sent++;
      end
    end
  endtask

  // receiver: long hold-off on request, else a rotating stall pattern
  always @(posedge clk) begin
    if (rst) begin
      m_tready  <= 1'b0;
      hold_left <= 0;
      rx_tick   <= '0;
    end else begin
      rx_tick <= rx_tick + 1'b1;
      if (hold_req != hold_ack) begin
        hold_ack  <= hold_req;
        hold_left <= LONG_HOLD;
        m_tready  <= 1'b0;
      end else if (hold_left != 0) begin
        hold_left <= hold_left - 1;
        m_tready  <= 1'b0;
      end else begin
        case (rx_tick[9:8])
          2'd0:    m_tready <= 1'b1;
          2'd1:    m_tready <= ($urandom_range(0, 1) == 0);
          2'd2:    m_tready <= (rx_tick[2:0] == 3'd0);
          default: m_tready <= ($urandom_range(0, 3) != 0);
        endcase
      end
    end
  end

  // compare each result transaction with the oldest expectation
  always @(posedge clk) begin : check_results
    console_result_t got;
    console_result_t want;
    if (!rst && m_tvalid && m_tready) begin
      got = m_tdata[27:0];
      if (pending_results.size() == 0) begin
        report_error("unexpected result", got, 0);
      end else begin
        want = pending_results.pop_front();
        if (got.pos != want.pos) report_error("cursor_pos", got.pos, want.pos);
        if (got.chr != want.chr) report_error("read_char", got.chr, want.chr);
        if (got.attr != want.attr) report_error("read_attr", got.attr, want.attr);
        if (got.scrolled != want.scrolled) report_error("scrolled", got.scrolled, want.scrolled);
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == LIMIT_CYCLES) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_reset_screen();
    test_put_basic();
    test_clear_defaults();
    run_text_phase(300, 1'b0);

    set_attrs(8'hff, 8'h00, 8'h00);
    run_text_phase(220, 1'b1);

    set_attrs(8'h00, 8'hff, 8'hff);
    test_result_backpressure(40);
    run_text_phase(220, 1'b1);

    set_attrs(8'($urandom), 8'($urandom), 8'($urandom));
    run_text_phase(160, 1'b1);

    drain(200);
    if (error_count == 0) $display("ALL CHECKS PASSED");
    else $display("CHECKS FAILED");
    $finish;
  end

endmodule

// ===== sim.f =====
sv/tcw_pkg.sv
sv/tcw_ctrl.sv
sv/tcw_datapath.sv
sv/text_console_writer.sv
sv/tcw_checker.sv
tb/tb.sv
